/* hw/rtl/nfbc_pkg.sv */
// nfbc_pkg: shared types, codes and helpers for the nand flash bank controller
// used by nfbc_cmd_decode and nand_flash_bank_controller; no dependencies

package nfbc_pkg;

  // request kinds
  localparam logic [1:0] KIND_RD  = 2'd0;
  localparam logic [1:0] KIND_WR  = 2'd1;
  localparam logic [1:0] KIND_RUN = 2'd2;
  localparam logic [1:0] KIND_ACK = 2'd3;

  // register indexes
  localparam logic [2:0] REG_CTRL = 3'd0;
  localparam logic [2:0] REG_CFG  = 3'd1;
  localparam logic [2:0] REG_ADR1 = 3'd2;
  localparam logic [2:0] REG_ADR2 = 3'd3;
  localparam logic [2:0] REG_DBUF = 3'd4;
  localparam logic [2:0] REG_EBUF = 3'd5;
  localparam logic [2:0] REG_BANK = 3'd6;

  // flash commands
  localparam logic [7:0] CMD_READ1    = 8'h00;
  localparam logic [7:0] CMD_PROG2    = 8'h10;
  localparam logic [7:0] CMD_READ2    = 8'h30;
  localparam logic [7:0] CMD_ERASE1   = 8'h60;
  localparam logic [7:0] CMD_STATUS   = 8'h70;
  localparam logic [7:0] CMD_PROG     = 8'h80;
  localparam logic [7:0] CMD_COPYBACK = 8'h85;
  localparam logic [7:0] CMD_READID   = 8'h90;
  localparam logic [7:0] CMD_ERASE2   = 8'hD0;
  localparam logic [7:0] CMD_RESET    = 8'hFF;

  // dma operations
  localparam logic [1:0] OP_F2M  = 2'd0;
  localparam logic [1:0] OP_M2F  = 2'd1;
  localparam logic [1:0] OP_ZERO = 2'd2;
  localparam logic [1:0] OP_ID   = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_REG = 2'd1;
  localparam logic [1:0] ST_BAD_LEN = 2'd2;
  localparam logic [1:0] ST_BAD_CMD = 2'd3;

  // page geometry
  localparam logic [11:0] SPARE_LEN  = 12'h040;
  localparam logic [11:0] PAGE_LEN   = 12'h840;
  localparam logic [11:0] DATA_LEN   = 12'h800;
  localparam logic [11:0] ID_LEN     = 12'h002;
  localparam logic [11:0] ECC_LEN    = 12'h010;
  localparam logic [35:0] OFF_SPARE  = 36'h800;
  localparam logic [35:0] OFF_ECC    = 36'h830;
  localparam logic [35:0] OFF_NEXT   = 36'h840;
  localparam logic [31:0] ECC_TOGGLE = 32'h40;

  typedef struct packed {
    logic [31:0] rdata;
    logic        is_dma;
    logic [1:0]  dma_op;
    logic [31:0] mem_addr;
    logic        flash_bank;
    logic [35:0] flash_offset;
    logic [11:0] xfer_len;
    logic [1:0]  status;
  } res_t;

  typedef struct packed {
    res_t [3:0]  desc;
    logic [2:0]  cnt;
    logic [1:0]  status;
    logic        do_reset;
  } dec_t;

  function automatic res_t mk_desc(input logic [1:0] op, input logic [31:0] mem,
                                   input logic bank, input logic [35:0] off,
                                   input logic [11:0] len);
    res_t r;
    r              = '0;
    r.is_dma       = 1'b1;
    r.dma_op       = op;
    r.mem_addr     = mem;
    r.flash_bank   = bank;
    r.flash_offset = off;
    r.xfer_len     = len;
    return r;
  endfunction

endpackage

/* hw/rtl/nand_flash_bank_controller.sv */
// nand_flash_bank_controller: register file, address merge and result sequencing
// a request is registered in the input stage; its results are then registered in the result bundle
// register and drained from it one per cycle while out_tready is high, one to four per request
// reset: synchronous active-low rst_n clears the register file, flags and valid bits
// depends on nfbc_pkg and nfbc_cmd_decode

module nand_flash_bank_controller (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [39:0]  in_tdata,   // reg_index[2:0], wdata[34:3], zero pad
  input  logic [1:0]   in_tuser,   // kind[1:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [119:0] out_tdata,  // rdata[31:0], dma_op[33:32], mem_addr[65:34],
                                   // flash_bank[66], flash_offset[102:67],
                                   // xfer_len[114:103], status[116:115], irq[117], zero pad
  output logic [0:0]   out_tuser,  // is_dma[0]
  output logic         out_tlast
);

  // register file
  logic [30:0] ctrl_r, ctrl_nxt;
  logic [31:0] cfg_r, cfg_nxt;
  logic [31:0] adr1_r, adr1_nxt;
  logic [31:0] adr2_r, adr2_nxt;
  logic [31:0] dbuf_r, dbuf_nxt;
  logic [31:0] ebuf_r, ebuf_nxt;
  logic [23:0] pn_r, pn_nxt;
  logic [10:0] po_r, po_nxt;
  logic        main_r, main_nxt;
  logic        irq_r, irq_nxt;

  // input stage
  logic        iv_r;
  logic [1:0]  ikind_r;
  logic [2:0]  ireg_r;
  logic [31:0] iwdata_r;

  // result bundle
  logic                   bv_r;
  nfbc_pkg::res_t [3:0]   bres_r, bres_nxt;
  logic [1:0]             bcnt_r, bcnt_nxt;
  logic [1:0]             bidx_r;
  logic                   birq_r;

  logic                   load;
  logic                   blast;
  logic                   run;
  logic [31:0]            word;
  logic [4:0]             mask;
  logic [23:0]            pn_m;
  logic [10:0]            po_m;
  nfbc_pkg::dec_t         dec;
  nfbc_pkg::res_t         single;
  nfbc_pkg::res_t         sel;

  assign blast     = (bidx_r == bcnt_r);
  assign load      = iv_r && (!bv_r || (out_tready && blast));
  assign in_tready = !iv_r || load;

  assign run  = (ikind_r == nfbc_pkg::KIND_RUN) ||
                ((ikind_r == nfbc_pkg::KIND_WR) && (ireg_r == nfbc_pkg::REG_CTRL) &&
                 iwdata_r[31]);
  assign word = (ikind_r == nfbc_pkg::KIND_RUN) ? cfg_r : {1'b0, iwdata_r[30:0]};
  assign mask = word[28:24];

  // address merge
  assign po_m[7:0]   = mask[0] ? adr1_r[7:0]   : po_r[7:0];
  assign po_m[10:8]  = mask[1] ? adr1_r[10:8]  : po_r[10:8];
  assign pn_m[7:0]   = mask[2] ? adr2_r[7:0]   : pn_r[7:0];
  assign pn_m[15:8]  = mask[3] ? adr2_r[15:8]  : pn_r[15:8];
  assign pn_m[23:16] = mask[4] ? adr2_r[23:16] : pn_r[23:16];

  nfbc_cmd_decode u_dec (
    .word     (word),
    .page_num (pn_m),
    .page_off (po_m),
    .bank     (main_r),
    .dbuf     (dbuf_r),
    .ebuf     (ebuf_r),
    .dec      (dec)
  );

  // state update
  always_comb begin
    ctrl_nxt = ctrl_r;
    cfg_nxt  = cfg_r;
    adr1_nxt = adr1_r;
    adr2_nxt = adr2_r;
    dbuf_nxt = dbuf_r;
    ebuf_nxt = ebuf_r;
    pn_nxt   = pn_r;
    po_nxt   = po_r;
    main_nxt = main_r;
    irq_nxt  = irq_r;
    case (ikind_r)
      nfbc_pkg::KIND_WR: begin
        unique case (ireg_r)
          nfbc_pkg::REG_CTRL: ctrl_nxt = iwdata_r[30:0];
          nfbc_pkg::REG_CFG:  cfg_nxt  = iwdata_r;
          nfbc_pkg::REG_ADR1: adr1_nxt = iwdata_r;
          nfbc_pkg::REG_ADR2: adr2_nxt = iwdata_r;
          nfbc_pkg::REG_DBUF: dbuf_nxt = iwdata_r;
          nfbc_pkg::REG_EBUF: ebuf_nxt = iwdata_r;
          nfbc_pkg::REG_BANK: main_nxt = iwdata_r[1];
          default: ;
        endcase
      end
      nfbc_pkg::KIND_RUN: cfg_nxt = {1'b0, cfg_r[30:0]};
      nfbc_pkg::KIND_ACK: irq_nxt = 1'b0;
      default: ;
    endcase
    if (run) begin
      pn_nxt = pn_m;
      po_nxt = po_m;
      if (dec.do_reset) begin
        ctrl_nxt = '0;
        cfg_nxt  = '0;
        adr1_nxt = '0;
        adr2_nxt = '0;
        dbuf_nxt = '0;
        ebuf_nxt = '0;
        pn_nxt   = '0;
        po_nxt   = '0;
        main_nxt = 1'b0;
      end
      if (word[30]) begin
        irq_nxt = 1'b1;
      end
    end
  end

  // result assembly
  always_comb begin
    single = '0;
    case (ikind_r)
      nfbc_pkg::KIND_RD: begin
        unique case (ireg_r)
          nfbc_pkg::REG_CTRL: single.rdata = {1'b0, ctrl_r};
          nfbc_pkg::REG_DBUF: single.rdata = dbuf_r;
          nfbc_pkg::REG_EBUF: single.rdata = ebuf_r;
          default:            single.status = nfbc_pkg::ST_BAD_REG;
        endcase
      end
      nfbc_pkg::KIND_WR: begin
        if (run) begin
          single.status = dec.status;
        end else if (ireg_r > nfbc_pkg::REG_BANK) begin
          single.status = nfbc_pkg::ST_BAD_REG;
        end
      end
      nfbc_pkg::KIND_RUN: single.status = dec.status;
      default:            single.rdata  = {31'b0, irq_r};
    endcase
    if (run && (dec.cnt != 3'd0)) begin
      bres_nxt = dec.desc;
      bcnt_nxt = dec.cnt[1:0] - 2'd1;
    end else begin
      bres_nxt    = '0;
      bres_nxt[0] = single;
      bcnt_nxt    = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
      cfg_r  <= '0;
      adr1_r <= '0;
      adr2_r <= '0;
      dbuf_r <= '0;
      ebuf_r <= '0;
      pn_r   <= '0;
      po_r   <= '0;
      main_r <= 1'b0;
      irq_r  <= 1'b0;
      iv_r   <= 1'b0;
      bv_r   <= 1'b0;
      bidx_r <= '0;
      bcnt_r <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        iv_r <= 1'b1;
      end else if (load) begin
        iv_r <= 1'b0;
      end
      if (load) begin
        ctrl_r <= ctrl_nxt;
        cfg_r  <= cfg_nxt;
        adr1_r <= adr1_nxt;
        adr2_r <= adr2_nxt;
        dbuf_r <= dbuf_nxt;
        ebuf_r <= ebuf_nxt;
        pn_r   <= pn_nxt;
        po_r   <= po_nxt;
        main_r <= main_nxt;
        irq_r  <= irq_nxt;
        bv_r   <= 1'b1;
        bidx_r <= '0;
        bcnt_r <= bcnt_nxt;
      end else if (bv_r && out_tready) begin
        if (blast) begin
          bv_r <= 1'b0;
        end else begin
          bidx_r <= bidx_r + 2'd1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      ikind_r  <= in_tuser;
      ireg_r   <= in_tdata[2:0];
      iwdata_r <= in_tdata[34:3];
    end
    if (load) begin
      bres_r <= bres_nxt;
      birq_r <= irq_nxt;
    end
  end

  assign sel        = bres_r[bidx_r];
  assign out_tvalid = bv_r;
  assign out_tlast  = blast;
  assign out_tuser  = sel.is_dma;
  assign out_tdata  = {2'b0, birq_r, sel.status, sel.xfer_len, sel.flash_offset,
                       sel.flash_bank, sel.mem_addr, sel.dma_op, sel.rdata};

endmodule

/* hw/rtl/nfbc_cmd_decode.sv */
// nfbc_cmd_decode: turns a control word and the merged page address into dma
// descriptors, a status code and a reset request; depends on nfbc_pkg

module nfbc_cmd_decode (
  input  logic [31:0]   word,
  input  logic [23:0]   page_num,
  input  logic [10:0]   page_off,
  input  logic          bank,
  input  logic [31:0]   dbuf,
  input  logic [31:0]   ebuf,
  output nfbc_pkg::dec_t dec
);

  logic [7:0]  cmd;
  logic [11:0] len;
  logic [35:0] pn_ext;
  logic [35:0] base;
  logic [35:0] off_spare;
  logic [35:0] off_ecc;
  logic [35:0] off_head;
  logic [35:0] off_tail;
  logic [11:0] head_len;
  logic [31:0] tail_mem;

  assign cmd       = word[23:16];
  assign len       = word[11:0];
  assign pn_ext    = {12'b0, page_num};
  assign base      = (pn_ext << 11) + (pn_ext << 6);
  assign off_spare = base + nfbc_pkg::OFF_SPARE;
  assign off_ecc   = base + nfbc_pkg::OFF_ECC;
  assign off_head  = base + {25'b0, page_off};
  assign off_tail  = base + nfbc_pkg::OFF_NEXT;
  assign head_len  = nfbc_pkg::DATA_LEN - {1'b0, page_off};
  assign tail_mem  = dbuf + {20'b0, nfbc_pkg::DATA_LEN} - {21'b0, page_off};

  always_comb begin
    dec = '0;
    unique case (cmd) inside
      nfbc_pkg::CMD_READ2: begin
        if (len == nfbc_pkg::SPARE_LEN) begin
          dec.desc[0] = nfbc_pkg::mk_desc(nfbc_pkg::OP_F2M, dbuf, bank, off_spare,
                                          nfbc_pkg::SPARE_LEN);
          dec.cnt     = 3'd1;
        end else if (len == nfbc_pkg::PAGE_LEN) begin
          dec.desc[0] = nfbc_pkg::mk_desc(nfbc_pkg::OP_F2M, ebuf, bank, off_spare,
                                          nfbc_pkg::SPARE_LEN);
          dec.desc[1] = nfbc_pkg::mk_desc(nfbc_pkg::OP_F2M, ebuf ^ nfbc_pkg::ECC_TOGGLE,
                                          bank, off_ecc, nfbc_pkg::ECC_LEN);
          dec.desc[2] = nfbc_pkg::mk_desc(nfbc_pkg::OP_F2M, dbuf, bank, off_head, head_len);
          dec.desc[3] = nfbc_pkg::mk_desc(nfbc_pkg::OP_F2M, tail_mem, bank, off_tail,
                                          {1'b0, page_off});
          dec.cnt     = 3'd4;
        end else begin
          dec.status = nfbc_pkg::ST_BAD_LEN;
        end
      end
      nfbc_pkg::CMD_STATUS: begin
        dec.desc[0] = nfbc_pkg::mk_desc(nfbc_pkg::OP_ZERO, dbuf, 1'b0, '0,
                                        nfbc_pkg::SPARE_LEN);
        dec.cnt     = 3'd1;
      end
      nfbc_pkg::CMD_PROG: begin
        dec.desc[0] = nfbc_pkg::mk_desc(nfbc_pkg::OP_M2F, dbuf, bank, off_head, head_len);
        dec.desc[1] = nfbc_pkg::mk_desc(nfbc_pkg::OP_M2F, tail_mem, bank, off_tail,
                                        {1'b0, page_off});
        dec.cnt     = 3'd2;
      end
      nfbc_pkg::CMD_COPYBACK: begin
        dec.desc[0] = nfbc_pkg::mk_desc(nfbc_pkg::OP_M2F, dbuf, bank, off_spare,
                                        nfbc_pkg::SPARE_LEN);
        dec.cnt     = 3'd1;
      end
      nfbc_pkg::CMD_READID: begin
        dec.desc[0] = nfbc_pkg::mk_desc(nfbc_pkg::OP_ID, dbuf, 1'b0, '0, nfbc_pkg::ID_LEN);
        dec.cnt     = 3'd1;
      end
      nfbc_pkg::CMD_RESET: begin
        dec.do_reset = 1'b1;
      end
      nfbc_pkg::CMD_READ1, nfbc_pkg::CMD_PROG2, nfbc_pkg::CMD_ERASE1,
      nfbc_pkg::CMD_ERASE2: begin
        dec.status = nfbc_pkg::ST_OK;
      end
      default: begin
        dec.status = nfbc_pkg::ST_BAD_CMD;
      end
    endcase
  end

endmodule

/* verif/tb_top.sv */
// tb_top: self-checking bench for nand_flash_bank_controller, register and command requests
// a scoreboard class predicts every result and descriptor; plain tasks drive the request stream
// and an initial block drives out_tready; depends on nfbc_pkg and the controller rtl

typedef struct packed {
  nfbc_pkg::res_t body;
  logic irq;
  logic last;
} bank_result_t;

class flash_bank_scoreboard;
  logic [30:0] ctrl_reg;
  logic [31:0] cfg_reg;
  logic [31:0] addr_lo;
  logic [31:0] addr_hi;
  logic [31:0] data_buf;
  logic [31:0] ecc_buf;
  logic [23:0] page_num;
  logic [10:0] page_off;
  logic        main_image;
  logic        irq_flag;
  nfbc_pkg::res_t cmd_results[$];
  bank_result_t   pending_results[$];
  int mismatches;
  int n_requests;
  int n_results;
  int n_desc;
  int n_cmds;
  int n_rejects;

  function new();
    clear_regs();
    irq_flag   = 1'b0;
    mismatches = 0;
    n_requests = 0;
    n_results  = 0;
    n_desc     = 0;
    n_cmds     = 0;
    n_rejects  = 0;
  endfunction

  // everything but the interrupt flag
  function void clear_regs();
    ctrl_reg   = '0;
    cfg_reg    = '0;
    addr_lo    = '0;
    addr_hi    = '0;
    data_buf   = '0;
    ecc_buf    = '0;
    page_num   = '0;
    page_off   = '0;
    main_image = 1'b0;
  endfunction

  function nfbc_pkg::res_t plain_result(logic [31:0] rd, logic [1:0] st);
    nfbc_pkg::res_t r;
    r        = '0;
    r.rdata  = rd;
    r.status = st;
    return r;
  endfunction

  function nfbc_pkg::res_t dma_entry(logic [1:0] op, logic [31:0] mem, logic img,
                                     logic [35:0] off, logic [11:0] len);
    nfbc_pkg::res_t r;
    r              = '0;
    r.is_dma       = 1'b1;
    r.dma_op       = op;
    r.mem_addr     = mem;
    r.flash_bank   = img;
    r.flash_offset = off;
    r.xfer_len     = len;
    return r;
  endfunction

  function void apply_command(logic [31:0] w);
    logic [7:0]  cmd;
    logic [11:0] len;
    logic [35:0] base;
    logic [11:0] po12;
    logic [31:0] tail_mem;
    cmd = w[23:16];
    len = w[11:0];
    if (w[24]) page_off[7:0]   = addr_lo[7:0];
    if (w[25]) page_off[10:8]  = addr_lo[10:8];
    if (w[26]) page_num[7:0]   = addr_hi[7:0];
    if (w[27]) page_num[15:8]  = addr_hi[15:8];
    if (w[28]) page_num[23:16] = addr_hi[23:16];
    base     = {12'd0, page_num} * nfbc_pkg::OFF_NEXT;
    po12     = {1'b0, page_off};
    tail_mem = data_buf + {20'd0, nfbc_pkg::DATA_LEN} - {20'd0, po12};
    n_cmds++;
    case (cmd)
      nfbc_pkg::CMD_READ2: begin
        if (len == nfbc_pkg::SPARE_LEN) begin
          cmd_results.push_back(dma_entry(nfbc_pkg::OP_F2M, data_buf, main_image,
                                          base + nfbc_pkg::OFF_SPARE, nfbc_pkg::SPARE_LEN));
        end else if (len == nfbc_pkg::PAGE_LEN) begin
          cmd_results.push_back(dma_entry(nfbc_pkg::OP_F2M, ecc_buf, main_image,
                                          base + nfbc_pkg::OFF_SPARE, nfbc_pkg::SPARE_LEN));
          cmd_results.push_back(dma_entry(nfbc_pkg::OP_F2M, ecc_buf ^ nfbc_pkg::ECC_TOGGLE,
                                          main_image, base + nfbc_pkg::OFF_ECC,
                                          nfbc_pkg::ECC_LEN));
          cmd_results.push_back(dma_entry(nfbc_pkg::OP_F2M, data_buf, main_image,
                                          base + {24'd0, po12}, nfbc_pkg::DATA_LEN - po12));
          cmd_results.push_back(dma_entry(nfbc_pkg::OP_F2M, tail_mem, main_image,
                                          base + nfbc_pkg::OFF_NEXT, po12));
        end else begin
          cmd_results.push_back(plain_result('0, nfbc_pkg::ST_BAD_LEN));
          n_rejects++;
        end
      end
      nfbc_pkg::CMD_STATUS: begin
        cmd_results.push_back(dma_entry(nfbc_pkg::OP_ZERO, data_buf, 1'b0, '0,
                                        nfbc_pkg::SPARE_LEN));
      end
      nfbc_pkg::CMD_PROG: begin
        cmd_results.push_back(dma_entry(nfbc_pkg::OP_M2F, data_buf, main_image,
                                        base + {24'd0, po12}, nfbc_pkg::DATA_LEN - po12));
        cmd_results.push_back(dma_entry(nfbc_pkg::OP_M2F, tail_mem, main_image,
                                        base + nfbc_pkg::OFF_NEXT, po12));
      end
      nfbc_pkg::CMD_COPYBACK: begin
        cmd_results.push_back(dma_entry(nfbc_pkg::OP_M2F, data_buf, main_image,
                                        base + nfbc_pkg::OFF_SPARE, nfbc_pkg::SPARE_LEN));
      end
      nfbc_pkg::CMD_READID: begin
        cmd_results.push_back(dma_entry(nfbc_pkg::OP_ID, data_buf, 1'b0, '0,
                                        nfbc_pkg::ID_LEN));
      end
      nfbc_pkg::CMD_RESET: begin
        clear_regs();
      end
      nfbc_pkg::CMD_READ1, nfbc_pkg::CMD_PROG2, nfbc_pkg::CMD_ERASE1,
      nfbc_pkg::CMD_ERASE2: ;
      default: begin
        cmd_results.push_back(plain_result('0, nfbc_pkg::ST_BAD_CMD));
        n_rejects++;
      end
    endcase
    if (w[30]) irq_flag = 1'b1;
  endfunction

  function void note_request(logic [1:0] req_kind, logic [2:0] idx, logic [31:0] value);
    logic         bad;
    logic         was;
    bank_result_t e;
    cmd_results.delete();
    bad = 1'b0;
    n_requests++;
    case (req_kind)
      nfbc_pkg::KIND_RD: begin
        case (idx)
          nfbc_pkg::REG_CTRL:
            cmd_results.push_back(plain_result({1'b0, ctrl_reg}, nfbc_pkg::ST_OK));
          nfbc_pkg::REG_DBUF: cmd_results.push_back(plain_result(data_buf, nfbc_pkg::ST_OK));
          nfbc_pkg::REG_EBUF: cmd_results.push_back(plain_result(ecc_buf, nfbc_pkg::ST_OK));
          default:  cmd_results.push_back(plain_result('0, nfbc_pkg::ST_BAD_REG));
        endcase
      end
      nfbc_pkg::KIND_WR: begin
        case (idx)
          nfbc_pkg::REG_CTRL: begin
            ctrl_reg = value[30:0];
            if (value[31]) apply_command({1'b0, value[30:0]});
          end
          nfbc_pkg::REG_CFG:  cfg_reg    = value;
          nfbc_pkg::REG_ADR1: addr_lo    = value;
          nfbc_pkg::REG_ADR2: addr_hi    = value;
          nfbc_pkg::REG_DBUF: data_buf   = value;
          nfbc_pkg::REG_EBUF: ecc_buf    = value;
          nfbc_pkg::REG_BANK: main_image = value[1];
          default:  bad        = 1'b1;
        endcase
        if (cmd_results.size() == 0)
          cmd_results.push_back(plain_result('0, bad ? nfbc_pkg::ST_BAD_REG : nfbc_pkg::ST_OK));
      end
      nfbc_pkg::KIND_RUN: begin
        apply_command(cfg_reg);
        cfg_reg[31] = 1'b0;
        if (cmd_results.size() == 0) cmd_results.push_back(plain_result('0, nfbc_pkg::ST_OK));
      end
      default: begin
        was      = irq_flag;
        irq_flag = 1'b0;
        cmd_results.push_back(plain_result({31'd0, was}, nfbc_pkg::ST_OK));
      end
    endcase
    foreach (cmd_results[i]) begin
      e.body = cmd_results[i];
      e.irq  = irq_flag;
      e.last = (i == cmd_results.size() - 1);
      pending_results.push_back(e);
    end
  endfunction

  function int outstanding();
    return pending_results.size();
  endfunction

  task report_mismatch(string what, logic [35:0] got, logic [35:0] want);
    $display("[%0t] result %0d: %s got %h want %h", $time, n_results, what, got, want);
    mismatches++;
  endtask

  task compare_field(string name, logic [35:0] got, logic [35:0] want);
    if (got !== want) report_mismatch(name, got, want);
  endtask

  task check_result(bank_result_t got);
    bank_result_t want;
    n_results++;
    if (got.body.is_dma === 1'b1) n_desc++;
    if (pending_results.size() == 0) begin
      report_mismatch("result with nothing pending", 36'(got.body.rdata), '0);
      return;
    end
    want = pending_results.pop_front();
    compare_field("rdata", 36'(got.body.rdata), 36'(want.body.rdata));
    compare_field("is_dma", 36'(got.body.is_dma), 36'(want.body.is_dma));
    compare_field("dma_op", 36'(got.body.dma_op), 36'(want.body.dma_op));
    compare_field("mem_addr", 36'(got.body.mem_addr), 36'(want.body.mem_addr));
    compare_field("flash_bank", 36'(got.body.flash_bank), 36'(want.body.flash_bank));
    compare_field("flash_offset", got.body.flash_offset, want.body.flash_offset);
    compare_field("xfer_len", 36'(got.body.xfer_len), 36'(want.body.xfer_len));
    compare_field("status", 36'(got.body.status), 36'(want.body.status));
    compare_field("irq", 36'(got.irq), 36'(want.irq));
    compare_field("last", 36'(got.last), 36'(want.last));
  endtask

  task flush_leftovers();
    if (pending_results.size() != 0)
      report_mismatch("results never delivered", '0, 36'(pending_results.size()));
  endtask
endclass

module tb_top;
  localparam logic [2:0] REG_NONE    = 3'd7;
  localparam logic [7:0] CMD_BOGUS   = 8'h42;
  localparam int         STALL_LIMIT = 2000;
  localparam int         HOLD_CYCLES = 80;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [39:0]  in_tdata   = '0;
  logic [1:0]   in_tuser   = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [119:0] out_tdata;
  logic [0:0]   out_tuser;
  logic         out_tlast;

  flash_bank_scoreboard sb;
  bank_result_t         seen;
  bit                   tx_idle     = 1'b0;
  bit                   rx_idle     = 1'b0;
  bit                   hold_off_req = 1'b0;
  int                   n_sent      = 0;
  int                   quiet_count = 0;

  nand_flash_bank_controller i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap(bit enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // unused bits of the word are left random
  function automatic logic [31:0] ctrl_word(bit go, bit raise, logic [4:0] mask,
                                            logic [7:0] cmd, logic [11:0] len);
    logic [31:0] w;
    w        = $urandom;
    w[31]    = go;
    w[30]    = raise;
    w[28:24] = mask;
    w[23:16] = cmd;
    w[11:0]  = len;
    return w;
  endfunction

  function automatic logic [7:0] pick_command();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return nfbc_pkg::CMD_READ2;
    if (r < 37) return nfbc_pkg::CMD_PROG;
    if (r < 47) return nfbc_pkg::CMD_STATUS;
    if (r < 57) return nfbc_pkg::CMD_COPYBACK;
    if (r < 67) return nfbc_pkg::CMD_READID;
    if (r < 72) return nfbc_pkg::CMD_RESET;
    if (r < 76) return nfbc_pkg::CMD_READ1;
    if (r < 80) return nfbc_pkg::CMD_PROG2;
    if (r < 84) return nfbc_pkg::CMD_ERASE1;
    if (r < 88) return nfbc_pkg::CMD_ERASE2;
    return 8'($urandom);
  endfunction

  function automatic logic [11:0] pick_length(logic [7:0] cmd);
    int r;
    r = $urandom_range(0, 99);
    if (cmd != nfbc_pkg::CMD_READ2 || r >= 80) return 12'($urandom);
    return (r < 40) ? nfbc_pkg::SPARE_LEN : nfbc_pkg::PAGE_LEN;
  endfunction

  task automatic send_request(logic [1:0] req_kind, logic [2:0] idx, logic [31:0] value);
    int gap;
    gap = pick_gap(tx_idle);
    repeat (gap) begin
      @(negedge clk);
      in_tvalid = 1'b0;
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = req_kind;
    in_tdata  = {5'd0, value, idx};
    do @(posedge clk); while (!in_tready);
    sb.note_request(req_kind, idx, value);
    n_sent++;
  endtask

  task automatic release_bus();
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // set up some of the address, buffer and bank registers, then run one command
  task automatic command_sequence();
    logic [7:0]  cmd;
    logic [31:0] w;
    if ($urandom_range(0, 99) < 40) send_request(nfbc_pkg::KIND_WR, nfbc_pkg::REG_ADR1, $urandom);
    if ($urandom_range(0, 99) < 40) send_request(nfbc_pkg::KIND_WR, nfbc_pkg::REG_ADR2, $urandom);
    if ($urandom_range(0, 99) < 30) send_request(nfbc_pkg::KIND_WR, nfbc_pkg::REG_DBUF, $urandom);
    if ($urandom_range(0, 99) < 30) send_request(nfbc_pkg::KIND_WR, nfbc_pkg::REG_EBUF, $urandom);
    if ($urandom_range(0, 99) < 25) send_request(nfbc_pkg::KIND_WR, nfbc_pkg::REG_BANK, $urandom);
    cmd = pick_command();
    w   = ctrl_word(1'b1, 1'($urandom), 5'($urandom), cmd, pick_length(cmd));
    if ($urandom_range(0, 99) < 70) begin
      send_request(nfbc_pkg::KIND_WR, nfbc_pkg::REG_CTRL, w);
    end else begin
      w[31] = 1'($urandom);
      send_request(nfbc_pkg::KIND_WR, nfbc_pkg::REG_CFG, w);
      send_request(nfbc_pkg::KIND_RUN, 3'($urandom), $urandom);
    end
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) command_sequence();
    else if (r < 72) send_request(nfbc_pkg::KIND_RD, 3'($urandom), $urandom);
    else if (r < 80) send_request(nfbc_pkg::KIND_ACK, 3'($urandom), $urandom);
    else if (r < 92) send_request(2'($urandom), 3'($urandom), $urandom);
    else send_request(nfbc_pkg::KIND_WR, nfbc_pkg::REG_CTRL, $urandom & 32'h7FFF_FFFF);
  endtask

  // result side: random stalls plus the occasional long hold-off
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else begin
        out_tready = 1'b1;
        stall_left = pick_gap(rx_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen.body.rdata        = out_tdata[31:0];
      seen.body.is_dma       = out_tuser[0];
      seen.body.dma_op       = out_tdata[33:32];
      seen.body.mem_addr     = out_tdata[65:34];
      seen.body.flash_bank   = out_tdata[66];
      seen.body.flash_offset = out_tdata[102:67];
      seen.body.xfer_len     = out_tdata[114:103];
      seen.body.status       = out_tdata[116:115];
      seen.irq               = out_tdata[117];
      seen.last              = out_tlast;
      sb.check_result(seen);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_count <= 0;
    else quiet_count <= quiet_count + 1;
    if (quiet_count >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: field extremes, every command, odd registers
    send_request(nfbc_pkg::KIND_RD, nfbc_pkg::REG_CTRL, '0);
    send_request(nfbc_pkg::KIND_RD, REG_NONE, '1);
    send_request(nfbc_pkg::KIND_WR, REG_NONE, '1);
    send_request(nfbc_pkg::KIND_RD, nfbc_pkg::REG_CFG, '0);
    send_request(nfbc_pkg::KIND_WR, nfbc_pkg::REG_ADR1, '1);
    send_request(nfbc_pkg::KIND_WR, nfbc_pkg::REG_ADR2, '1);
    send_request(nfbc_pkg::KIND_WR, nfbc_pkg::REG_DBUF, 32'hFFFF_FF00);
    send_request(nfbc_pkg::KIND_WR, nfbc_pkg::REG_EBUF, 32'hFFFF_FFC0);
    send_request(nfbc_pkg::KIND_WR, nfbc_pkg::REG_BANK, 32'h0000_0002);
    send_request(nfbc_pkg::KIND_WR, nfbc_pkg::REG_CTRL,
                 ctrl_word(1'b1, 1'b1, 5'h1F, nfbc_pkg::CMD_READ2, nfbc_pkg::PAGE_LEN));
    send_request(nfbc_pkg::KIND_WR, nfbc_pkg::REG_CTRL,
                 ctrl_word(1'b1, 1'b0, 5'h00, nfbc_pkg::CMD_PROG, '0));
    send_request(nfbc_pkg::KIND_RD, nfbc_pkg::REG_CTRL, '0);
    send_request(nfbc_pkg::KIND_ACK, nfbc_pkg::REG_CTRL, '0);
    send_request(nfbc_pkg::KIND_ACK, REG_NONE, '1);
    send_request(nfbc_pkg::KIND_WR, nfbc_pkg::REG_ADR1, '0);
    send_request(nfbc_pkg::KIND_WR, nfbc_pkg::REG_CTRL,
                 ctrl_word(1'b1, 1'b0, 5'h03, nfbc_pkg::CMD_PROG, '1));
    send_request(nfbc_pkg::KIND_WR, nfbc_pkg::REG_CTRL,
                 ctrl_word(1'b1, 1'b0, 5'h00, nfbc_pkg::CMD_READ2, nfbc_pkg::SPARE_LEN));
    send_request(nfbc_pkg::KIND_WR, nfbc_pkg::REG_CTRL,
                 ctrl_word(1'b1, 1'b0, 5'h00, nfbc_pkg::CMD_READ2, 12'h123));
    send_request(nfbc_pkg::KIND_WR, nfbc_pkg::REG_CTRL,
                 ctrl_word(1'b1, 1'b0, 5'h00, nfbc_pkg::CMD_STATUS, '0));
    send_request(nfbc_pkg::KIND_WR, nfbc_pkg::REG_CTRL,
                 ctrl_word(1'b1, 1'b0, 5'h00, nfbc_pkg::CMD_READID, '0));
    send_request(nfbc_pkg::KIND_WR, nfbc_pkg::REG_CTRL,
                 ctrl_word(1'b1, 1'b1, 5'h00, CMD_BOGUS, '0));
    send_request(nfbc_pkg::KIND_WR, nfbc_pkg::REG_CTRL,
                 ctrl_word(1'b1, 1'b0, 5'h1F, nfbc_pkg::CMD_READ1, '0));
    send_request(nfbc_pkg::KIND_WR, nfbc_pkg::REG_CTRL,
                 ctrl_word(1'b1, 1'b0, 5'h00, nfbc_pkg::CMD_PROG2, '0));
    send_request(nfbc_pkg::KIND_WR, nfbc_pkg::REG_CTRL,
                 ctrl_word(1'b1, 1'b0, 5'h00, nfbc_pkg::CMD_ERASE1, '0));
    send_request(nfbc_pkg::KIND_WR, nfbc_pkg::REG_CTRL,
                 ctrl_word(1'b1, 1'b0, 5'h00, nfbc_pkg::CMD_ERASE2, '0));
    send_request(nfbc_pkg::KIND_WR, nfbc_pkg::REG_CFG,
                 ctrl_word(1'b1, 1'b0, 5'h1F, nfbc_pkg::CMD_COPYBACK, '0));
    send_request(nfbc_pkg::KIND_RUN, nfbc_pkg::REG_CTRL, '0);
    send_request(nfbc_pkg::KIND_RUN, REG_NONE, '1);
    send_request(nfbc_pkg::KIND_WR, nfbc_pkg::REG_CTRL,
                 ctrl_word(1'b1, 1'b1, 5'h00, nfbc_pkg::CMD_RESET, '0));
    send_request(nfbc_pkg::KIND_RD, nfbc_pkg::REG_DBUF, '0);
    send_request(nfbc_pkg::KIND_WR, nfbc_pkg::REG_BANK, 32'hFFFF_FFFD);
    send_request(nfbc_pkg::KIND_WR, nfbc_pkg::REG_CTRL,
                 ctrl_word(1'b1, 1'b0, 5'h00, nfbc_pkg::CMD_COPYBACK, '0));
    release_bus();
    wait_drained();

    tx_idle = 1'b1;
    rx_idle = 1'b1;
    while (n_sent < 100) random_item();

    // hold the result side off while requests keep coming
    release_bus();
    wait_drained();
    hold_off_req = 1'b1;
    tx_idle      = 1'b0;
    repeat (5) command_sequence();
    release_bus();
    wait_drained();

    // a stretch with no idling on either side
    rx_idle = 1'b0;
    while (n_sent < 140) random_item();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    while (n_sent < 180) random_item();

    release_bus();
    wait_drained();
    repeat (8) @(posedge clk);
    sb.flush_leftovers();
    $display("%0d requests sent, %0d results checked (%0d dma descriptors)",
             sb.n_requests, sb.n_results, sb.n_desc);
    $display("%0d commands run, %0d of them rejected; %0d mismatches",
             sb.n_cmds, sb.n_rejects, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
